### sv/bcpe_pkg.sv
// ----------------------------------------------------------------------------
// bcpe_pkg
// Shared types and constants for the B-spline curve point evaluator.
// ----------------------------------------------------------------------------
package bcpe_pkg;

  // default sizes of the point and knot stores
  localparam int MAX_CONTROLS_DEF = 64;
  localparam int KNOT_DEPTH_DEF   = 68;
  // degree register is two bits wide, so the triangle never exceeds cubic
  localparam int MAX_DEGREE       = 3;

  // one in Q16.16, as a 17-bit weight
  localparam logic [16:0] ONE_Q = 17'h10000;

  // input item modes
  typedef enum logic [1:0] {
    MODE_CTRL = 2'd0,
    MODE_KNOT = 2'd1,
    MODE_EVAL = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_DEGREE   = 2'd0,
    CFG_CONTROLS = 2'd1,
    CFG_KNOTS    = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_idx_e;

  // evaluation status codes
  typedef enum logic [1:0] {
    ST_DEBOOR = 2'd0,
    ST_BEZIER = 2'd1,
    ST_LINEAR = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // classified queue entry kinds
  typedef enum logic [1:0] {
    KIND_CTRL,
    KIND_KNOT,
    KIND_EVAL
  } kind_e;

  // back-end sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_CLS,
    S_BK5,
    S_BK6,
    S_BKC,
    S_BZ,
    S_GEN,
    S_DKL,
    S_DMUL,
    S_DU,
    S_DCL,
    S_DSP,
    S_SR0,
    S_SR1,
    S_SR2,
    S_LD,
    S_TA,
    S_TB,
    S_TC,
    S_DIV,
    S_LM,
    S_LA,
    S_OUT
  } bk_state_e;

  // one classified transaction between front and back
  typedef struct packed {
    kind_e              kind;
    logic [6:0]         slot;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [16:0]        t01;
  } item_t;

  // configuration register contents
  typedef struct packed {
    logic [1:0] degree;
    logic [6:0] controls;
    logic [6:0] knots;
  } cfg_t;

endpackage

### sv/bspline_curve_point_evaluator.sv
// ----------------------------------------------------------------------------
// bspline_curve_point_evaluator
// Evaluates 3-D points on a B-spline or piecewise cubic Bezier curve held in
// on-chip control point and knot stores, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries load and evaluate
//   transactions; mode selects control point load, knot load or evaluation.
//   Loads of an out-of-range slot and unused modes are dropped.
//   Output channel (out_valid_o / out_stall_i) returns one point and a status
//   for each evaluation; loads return nothing.
//   A two-entry queue parts the input side from the evaluation sequencer, and
//   a result register parts the sequencer from the output side.
//   Evaluations take a linear, a Bezier segment or a general de Boor path;
//   the general path adds a binary span search and, for each de Boor weight
//   that is not clamped, a division on the 16-step divider; every blended
//   point goes through the shared 33x18 multiplier. The sequencer takes the
//   next queued load or evaluation only once the current evaluation is done.
//   Reset empties the queue and the result register and sets degree 3 with
//   zero counts; the stores are not cleared.
//   A stalled output holds its result; the sequencer waits for the register
//   to free up before presenting the next one, and the input queue then fills.
// ----------------------------------------------------------------------------
module bspline_curve_point_evaluator #(
  parameter int MAX_CONTROLS = bcpe_pkg::MAX_CONTROLS_DEF,
  parameter int KNOT_DEPTH   = bcpe_pkg::KNOT_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [6:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          mode_i,
  input  logic [6:0]          slot_i,
  input  logic signed [31:0]  point_x_i,
  input  logic signed [31:0]  point_y_i,
  input  logic signed [31:0]  point_z_i,
  input  logic signed [31:0]  knot_value_i,
  input  logic signed [18:0]  param_t_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  result_x_o,
  output logic signed [31:0]  result_y_o,
  output logic signed [31:0]  result_z_o,
  output logic [1:0]          eval_status_o
);
  import bcpe_pkg::*;

  cfg_t  cfg_q;
  item_t head;
  logic  empty;
  logic  pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.degree   <= 2'd3;
      cfg_q.controls <= '0;
      cfg_q.knots    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DEGREE:   cfg_q.degree   <= cfg_data_i[1:0];
        CFG_CONTROLS: cfg_q.controls <= cfg_data_i;
        CFG_KNOTS:    cfg_q.knots    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // input classification and queue
  bcpe_front #(
    .MAX_CONTROLS (MAX_CONTROLS),
    .KNOT_DEPTH   (KNOT_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid     (in_valid_i),
    .in_stall     (in_stall_o),
    .mode_i       (mode_i),
    .slot_i       (slot_i),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .knot_value_i (knot_value_i),
    .param_t_i    (param_t_i),
    .head_o       (head),
    .empty_o      (empty),
    .pop_i        (pop)
  );

  // stores and evaluation sequencer
  bcpe_back #(
    .MAX_CONTROLS (MAX_CONTROLS),
    .KNOT_DEPTH   (KNOT_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .cfg_i         (cfg_q),
    .out_valid     (out_valid_o),
    .out_stall     (out_stall_i),
    .result_x_o    (result_x_o),
    .result_y_o    (result_y_o),
    .result_z_o    (result_z_o),
    .eval_status_o (eval_status_o)
  );

endmodule

### sv/bcpe_front.sv
// ----------------------------------------------------------------------------
// bcpe_front
// Accepts input transactions, drops unusable ones, clamps the parameter and
// queues the rest in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module bcpe_front #(
  parameter int MAX_CONTROLS = bcpe_pkg::MAX_CONTROLS_DEF,
  parameter int KNOT_DEPTH   = bcpe_pkg::KNOT_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          mode_i,
  input  logic [6:0]          slot_i,
  input  logic signed [31:0]  point_x_i,
  input  logic signed [31:0]  point_y_i,
  input  logic signed [31:0]  point_z_i,
  input  logic signed [31:0]  knot_value_i,
  input  logic signed [18:0]  param_t_i,
  output bcpe_pkg::item_t     head_o,
  output logic                empty_o,
  input  logic                pop_i
);
  import bcpe_pkg::*;

  item_t       fifo_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q;
  item_t       item;
  logic        keep;
  logic        push;
  logic        pop;

  // classify the incoming transaction
  always_comb begin
    item      = '0;
    item.slot = slot_i;
    keep      = 1'b0;
    case (mode_e'(mode_i))
      MODE_CTRL: begin
        item.kind = KIND_CTRL;
        item.x    = point_x_i;
        item.y    = point_y_i;
        item.z    = point_z_i;
        keep      = 32'(slot_i) < MAX_CONTROLS;
      end
      MODE_KNOT: begin
        item.kind = KIND_KNOT;
        item.x    = knot_value_i;
        keep      = 32'(slot_i) < KNOT_DEPTH;
      end
      MODE_EVAL: begin
        item.kind = KIND_EVAL;
        keep      = 1'b1;
        if (param_t_i < 0) begin
          item.t01 = '0;
        end else if (param_t_i > $signed({2'b00, ONE_Q})) begin
          item.t01 = ONE_Q;
        end else begin
          item.t01 = param_t_i[16:0];
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall = cnt_q == 2'd2;
  assign push     = in_valid && !in_stall && keep;
  assign pop      = pop_i && cnt_q != 2'd0;
  assign empty_o  = cnt_q == 2'd0;
  assign head_o   = fifo_q[rptr_q];

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wptr_q] <= item;
  end

endmodule

### sv/bcpe_back.sv
// ----------------------------------------------------------------------------
// bcpe_back
// Carries out queued transactions: store writes, and curve evaluation by a
// sequencer around one shared multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
module bcpe_back #(
  parameter int MAX_CONTROLS = bcpe_pkg::MAX_CONTROLS_DEF,
  parameter int KNOT_DEPTH   = bcpe_pkg::KNOT_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bcpe_pkg::item_t     head_i,
  input  logic                empty_i,
  output logic                pop_o,
  input  bcpe_pkg::cfg_t      cfg_i,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  result_x_o,
  output logic signed [31:0]  result_y_o,
  output logic signed [31:0]  result_z_o,
  output logic [1:0]          eval_status_o
);
  import bcpe_pkg::*;

  localparam int CAW = $clog2(MAX_CONTROLS);
  localparam int KAW = $clog2(KNOT_DEPTH);

  bk_state_e state_q, state_d;

  // stores
  logic [95:0]        cmem [MAX_CONTROLS];
  logic [95:0]        crd_q;
  logic [CAW-1:0]     c_addr;
  logic signed [31:0] kmem [KNOT_DEPTH];
  logic signed [31:0] krd_q;
  logic [KAW-1:0]     k_addr;

  // evaluation context
  logic [6:0]         n_q, kq_q;
  logic [16:0]        t_q, alpha_q;
  logic [5:0]         nseg_q;
  logic [1:0]         p_q, r_q, j_q, c_q;
  logic [7:0]         base_q;
  logic               lin_q, fixa_q;
  status_e            status_q;
  logic signed [31:0] k0_q, kp_q, kn_q, ki_q, kmid_q, u_q;
  logic [6:0]         lo_q, hi_q, mid;
  logic [2:0]         ld_q;
  logic signed [50:0] prod_q;
  logic [33:0]        rem_q;
  logic [32:0]        den_q;
  logic [15:0]        quo_q;
  logic [3:0]         dcnt_q;
  logic signed [31:0] d_q [4][3];

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;

  // combinational helpers
  logic [6:0]         n_c, kq_c, nm1;
  logic [14:0]        div3;
  logic [6:0]         nseg_c, rem3;
  logic               bez_c;
  logic [1:0]         pdeg;
  logic [7:0]         need_k;
  logic [22:0]        tt;
  logic [6:0]         seg_i;
  logic signed [32:0] den_c, num_c;
  logic [33:0]        rem_sh;
  logic signed [31:0] uc;
  logic [7:0]         ld_addr, ki_addr, kj_addr;
  logic               out_free;

  assign out_free = !out_valid || !out_stall;
  assign mid      = 7'((8'(lo_q) + 8'(hi_q)) >> 1);

  // counts saturated to the store sizes, Bezier shape test
  always_comb begin
    n_c    = (32'(cfg_i.controls) > MAX_CONTROLS) ? 7'(MAX_CONTROLS) : cfg_i.controls;
    kq_c   = (32'(cfg_i.knots) > KNOT_DEPTH) ? 7'(KNOT_DEPTH) : cfg_i.knots;
    nm1    = n_c - 7'd1;
    div3   = (15'(nm1) * 15'd171) >> 9;
    nseg_c = div3[6:0];
    rem3   = nm1 - 7'(nseg_c * 7'd3);
    bez_c  = cfg_i.degree == 2'd3 && n_c >= 7'd4 && rem3 == 7'd0 &&
             8'(kq_c) == 8'(n_c) + 8'd4;
    pdeg   = (cfg_i.degree == 2'd0) ? 2'd1 : cfg_i.degree;
    need_k = 8'(n_q) + 8'(pdeg) + 8'd1;
    tt     = 23'(t_q) * 23'(nseg_q);
    seg_i  = (tt[22:16] >= 7'(nseg_q)) ? 7'(nseg_q) - 7'd1 : tt[22:16];
    den_c  = 33'(krd_q) - 33'(ki_q);
    num_c  = 33'(u_q) - 33'(ki_q);
    rem_sh = {rem_q[32:0], 1'b0};
    uc     = (u_q < kp_q) ? kp_q : u_q;
    if (uc > krd_q) uc = krd_q;
    ld_addr = lin_q ? ((ld_q == 3'd0) ? 8'd0 : 8'(n_q) - 8'd1) : base_q + 8'(ld_q);
    ki_addr = base_q + 8'(j_q);
    kj_addr = base_q + 8'(j_q) + 8'(p_q) - 8'(r_q) + 8'd1;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (!empty_i && head_i.kind == KIND_EVAL) state_d = S_CLS;
      S_CLS: begin
        if (n_c == 7'd0) state_d = S_OUT;
        else if (bez_c) state_d = (nseg_c == 7'd1) ? S_BZ : S_BK5;
        else state_d = S_GEN;
      end
      S_BK5: state_d = S_BK6;
      S_BK6: state_d = S_BKC;
      S_BKC: state_d = (ki_q == kmid_q && kmid_q == krd_q) ? S_BZ : S_GEN;
      S_BZ:  state_d = S_LD;
      S_GEN: begin
        if (8'(kq_q) < need_k || n_q <= 7'(pdeg)) state_d = S_LD;
        else state_d = S_DKL;
      end
      S_DKL:  state_d = S_DMUL;
      S_DMUL: state_d = S_DU;
      S_DU:   state_d = S_DCL;
      S_DCL:  state_d = S_DSP;
      S_DSP: begin
        if (u_q >= kn_q || u_q <= kp_q) state_d = S_LD;
        else state_d = S_SR0;
      end
      S_SR0: state_d = (hi_q - lo_q <= 7'd1) ? S_LD : S_SR1;
      S_SR1: state_d = S_SR2;
      S_SR2: begin
        if (u_q < kmid_q || u_q >= krd_q) state_d = S_SR0;
        else state_d = S_LD;
      end
      S_LD: begin
        if (ld_q == 3'(p_q) + 3'd1) state_d = fixa_q ? S_LM : S_TA;
      end
      S_TA: state_d = S_TB;
      S_TB: state_d = S_TC;
      S_TC: begin
        if (den_c <= 0 || num_c <= 0 || num_c >= den_c) state_d = S_LM;
        else state_d = S_DIV;
      end
      S_DIV: if (dcnt_q == 4'd15) state_d = S_LM;
      S_LM:  state_d = S_LA;
      S_LA: begin
        if (c_q != 2'd2) state_d = S_LM;
        else if (j_q == r_q && r_q == p_q) state_d = S_OUT;
        else state_d = fixa_q ? S_LM : S_TA;
      end
      S_OUT: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs: queue pop, store addresses, multiplier operands
  always_comb begin
    pop_o  = 1'b0;
    k_addr = '0;
    c_addr = CAW'(ld_addr);
    mul_a  = 33'(d_q[j_q][c_q]) - 33'(d_q[j_q - 2'd1][c_q]);
    mul_b  = 18'(alpha_q);
    case (state_q)
      S_IDLE: pop_o = !empty_i;
      S_CLS:  k_addr = KAW'(4);
      S_BK5:  k_addr = KAW'(5);
      S_BK6:  k_addr = KAW'(6);
      S_GEN:  k_addr = '0;
      S_DKL:  k_addr = KAW'(8'(kq_q) - 8'd1);
      S_DMUL: begin
        k_addr = KAW'(p_q);
        mul_a  = 33'(krd_q) - 33'(k0_q);
        mul_b  = 18'(t_q);
      end
      S_DU:   k_addr = KAW'(n_q);
      S_SR0:  k_addr = KAW'(mid);
      S_SR1:  k_addr = KAW'(8'(mid) + 8'd1);
      S_TA:   k_addr = KAW'(ki_addr);
      S_TB:   k_addr = KAW'(kj_addr);
      default: k_addr = '0;
    endcase
  end

  // control point store
  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.kind == KIND_CTRL) begin
      cmem[CAW'(head_i.slot)] <= {head_i.x, head_i.y, head_i.z};
    end
    crd_q <= cmem[c_addr];
  end

  // knot store
  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.kind == KIND_KNOT) begin
      kmem[KAW'(head_i.slot)] <= head_i.x;
    end
    krd_q <= kmem[k_addr];
  end

  // control state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // evaluation datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: t_q <= head_i.t01;
      S_CLS: begin
        n_q      <= n_c;
        kq_q     <= kq_c;
        nseg_q   <= nseg_c[5:0];
        status_q <= ST_EMPTY;
      end
      S_BK5: ki_q   <= krd_q;
      S_BK6: kmid_q <= krd_q;
      S_BZ: begin
        alpha_q  <= tt[16:0] - {seg_i[0], 16'h0000};
        base_q   <= 8'(seg_i) * 8'd3;
        p_q      <= 2'd3;
        lin_q    <= 1'b0;
        fixa_q   <= 1'b1;
        ld_q     <= '0;
        status_q <= ST_BEZIER;
      end
      S_GEN: begin
        ld_q <= '0;
        if (8'(kq_q) < need_k || n_q <= 7'(pdeg)) begin
          p_q      <= 2'd1;
          lin_q    <= 1'b1;
          fixa_q   <= 1'b1;
          alpha_q  <= t_q;
          status_q <= ST_LINEAR;
        end else begin
          p_q      <= pdeg;
          lin_q    <= 1'b0;
          fixa_q   <= 1'b0;
          status_q <= ST_DEBOOR;
        end
      end
      S_DKL:  k0_q   <= krd_q;
      S_DMUL: prod_q <= mul_a * mul_b;
      S_DU: begin
        u_q  <= k0_q + prod_q[47:16];
        kp_q <= krd_q;
      end
      S_DCL: begin
        kn_q <= krd_q;
        u_q  <= uc;
      end
      S_DSP: begin
        lo_q <= 7'(p_q);
        hi_q <= n_q;
        if (u_q >= kn_q) base_q <= 8'(n_q) - 8'd1 - 8'(p_q);
        else base_q <= '0;
      end
      S_SR0: base_q <= 8'(mid) - 8'(p_q);
      S_SR1: kmid_q <= krd_q;
      S_SR2: begin
        if (u_q < kmid_q) hi_q <= mid;
        else if (u_q >= krd_q) lo_q <= mid;
      end
      S_LD: begin
        ld_q <= ld_q + 3'd1;
        if (ld_q != 3'd0) begin
          d_q[2'(ld_q - 3'd1)][0] <= crd_q[95:64];
          d_q[2'(ld_q - 3'd1)][1] <= crd_q[63:32];
          d_q[2'(ld_q - 3'd1)][2] <= crd_q[31:0];
        end
        r_q <= 2'd1;
        j_q <= p_q;
        c_q <= '0;
      end
      S_TB: ki_q <= krd_q;
      S_TC: begin
        c_q    <= '0;
        rem_q  <= 34'(num_c);
        den_q  <= den_c;
        quo_q  <= '0;
        dcnt_q <= '0;
        if (den_c <= 0 || num_c <= 0) alpha_q <= '0;
        else if (num_c >= den_c) alpha_q <= ONE_Q;
      end
      S_DIV: begin
        dcnt_q <= dcnt_q + 4'd1;
        if (rem_sh >= {1'b0, den_q}) begin
          rem_q <= rem_sh - {1'b0, den_q};
          quo_q <= {quo_q[14:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[14:0], 1'b0};
        end
        if (dcnt_q == 4'd15) begin
          alpha_q <= {1'b0, quo_q[14:0], rem_sh >= {1'b0, den_q}};
        end
      end
      S_LM: prod_q <= mul_a * mul_b;
      S_LA: begin
        d_q[j_q][c_q] <= d_q[j_q - 2'd1][c_q] + prod_q[47:16];
        if (c_q != 2'd2) begin
          c_q <= c_q + 2'd1;
        end else begin
          c_q <= '0;
          if (j_q == r_q) begin
            r_q <= r_q + 2'd1;
            j_q <= p_q;
          end else begin
            j_q <= j_q - 2'd1;
          end
        end
      end
      default: begin
      end
    endcase
    // span decided at the low end of the knot range
    if (state_q == S_DSP && u_q < kn_q && u_q <= kp_q) base_q <= '0;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      eval_status_o <= status_q;
      if (status_q == ST_EMPTY) begin
        result_x_o <= '0;
        result_y_o <= '0;
        result_z_o <= '0;
      end else begin
        result_x_o <= d_q[p_q][0];
        result_y_o <= d_q[p_q][1];
        result_z_o <= d_q[p_q][2];
      end
    end
  end

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the B-spline curve point evaluator. Fills the
// control point and knot stores, walks a set of register settings (empty,
// single and multi segment Bezier, clamped and broken knot vectors, short
// knot vectors, saturated counts) and checks every evaluated point against
// a Q16.16 predictor held in the bench. Both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import bcpe_pkg::*;

  // expected point for one evaluation
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    status_e     st;
  } point_t;

  // directed stimulus row
  typedef struct packed {
    mode_e       mode;
    logic [6:0]  slot;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] k;
    logic [18:0] t;
    bit          typed;
    point_t      want;
  } row_t;

  localparam int STALL_PCT = 32;
  localparam int WATCHDOG  = 20000;
  localparam int SETTLE    = 300;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CFG_DEGREE;
  logic [6:0]         cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         mode = MODE_NONE;
  logic [6:0]         slot = '0;
  logic signed [31:0] px = '0, py = '0, pz = '0, kv = '0;
  logic signed [18:0] pt = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] rx, ry, rz;
  logic [1:0]         rst_code;

  // bench copy of the block state
  longint ctrl_m [64][3];
  longint knot_m [68];
  int     deg_m, cnt_m, kn_m;

  point_t point_q[$];
  int     errors = 0;
  int     idle_cycles = 0;
  bit     calm = 1'b0;
  int     status_seen [4];

  bspline_curve_point_evaluator DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .mode_i(mode), .slot_i(slot),
    .point_x_i(px), .point_y_i(py), .point_z_i(pz),
    .knot_value_i(kv), .param_t_i(pt),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .result_x_o(rx), .result_y_o(ry), .result_z_o(rz),
    .eval_status_o(rst_code)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // weighted blend, floor of the Q16.16 product
  function automatic longint blend(longint a, longint b, longint w);
    return (a * (65536 - w) + b * w) >>> 16;
  endfunction

  // expected point for parameter tin under the current settings
  function automatic point_t predict_point(logic signed [18:0] tin);
    longint n, kq, t, p, nseg, tt, i, u, span, lo, hi, mid, k0, kl, den, alpha, idx;
    longint d [4][3];
    longint c [3][3];
    longint e [2][3];
    longint o [3];
    point_t r;
    int j, rr, ax;
    n  = cnt_m > 64 ? 64 : cnt_m;
    kq = kn_m > 68 ? 68 : kn_m;
    if (n == 0) begin
      r.x = '0; r.y = '0; r.z = '0; r.st = ST_EMPTY;
      return r;
    end
    t = tin;
    if (t < 0) t = 0;
    if (t > 65536) t = 65536;
    nseg = (n - 1) / 3;
    // piecewise cubic bezier, triple interior knots
    if (deg_m == 3 && n >= 4 && (n - 1) % 3 == 0 && kq == n + 4 &&
        (nseg == 1 || (knot_m[4] == knot_m[5] && knot_m[5] == knot_m[6]))) begin
      tt = t * nseg;
      i  = tt >>> 16;
      if (i >= nseg) i = nseg - 1;
      u = tt - i * 65536;
      for (ax = 0; ax < 3; ax++) begin
        for (j = 0; j < 3; j++) c[j][ax] = blend(ctrl_m[3*i+j][ax], ctrl_m[3*i+j+1][ax], u);
        for (j = 0; j < 2; j++) e[j][ax] = blend(c[j][ax], c[j+1][ax], u);
        o[ax] = blend(e[0][ax], e[1][ax], u);
      end
      r.st = ST_BEZIER;
    end else begin
      p = deg_m == 0 ? 1 : deg_m;
      if (kq < n + p + 1 || n <= p) begin
        // short knot vector or too few controls
        for (ax = 0; ax < 3; ax++) o[ax] = blend(ctrl_m[0][ax], ctrl_m[n-1][ax], t);
        r.st = ST_LINEAR;
      end else begin
        k0 = knot_m[0];
        kl = knot_m[kq-1];
        u  = k0 + ((t * (kl - k0)) >>> 16);
        if (u < knot_m[p]) u = knot_m[p];
        if (u > knot_m[n]) u = knot_m[n];
        if (u >= knot_m[n]) span = n - 1;
        else if (u <= knot_m[p]) span = p;
        else begin
          lo = p; hi = n; mid = (lo + hi) / 2;
          while (hi - lo > 1 && (u < knot_m[mid] || u >= knot_m[mid+1])) begin
            if (u < knot_m[mid]) hi = mid;
            else lo = mid;
            mid = (lo + hi) / 2;
          end
          span = mid;
        end
        for (j = 0; j <= p; j++)
          for (ax = 0; ax < 3; ax++) d[j][ax] = ctrl_m[span-p+j][ax];
        // de boor triangle, alpha clamped, zero on an empty gap
        for (rr = 1; rr <= p; rr++)
          for (j = p; j >= rr; j--) begin
            idx = span - p + j;
            den = knot_m[idx+p-rr+1] - knot_m[idx];
            alpha = 0;
            if (den > 0) begin
              alpha = ((u - knot_m[idx]) * 65536) / den;
              if (alpha < 0) alpha = 0;
              if (alpha > 65536) alpha = 65536;
            end
            for (ax = 0; ax < 3; ax++) d[j][ax] = blend(d[j-1][ax], d[j][ax], alpha);
          end
        for (ax = 0; ax < 3; ax++) o[ax] = d[p][ax];
        r.st = ST_DEBOOR;
      end
    end
    r.x = o[0][31:0]; r.y = o[1][31:0]; r.z = o[2][31:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, field, got, want);
    errors++;
  endtask

  // drive one transaction and wait for acceptance
  task automatic send_item(mode_e m, logic [6:0] s, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic [31:0] k, logic [18:0] t,
                           bit typed, point_t want);
    while (!calm && $urandom_range(99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m; slot <= s; px <= x; py <= y; pz <= z; kv <= k; pt <= t;
    do @(posedge clk); while (in_stall);
    case (m)
      MODE_CTRL: if (s < 64) begin
        ctrl_m[s][0] = longint'($signed(x));
        ctrl_m[s][1] = longint'($signed(y));
        ctrl_m[s][2] = longint'($signed(z));
      end
      MODE_KNOT: if (s < 68) knot_m[s] = longint'($signed(k));
      MODE_EVAL: point_q.push_back(typed ? want : predict_point(t));
      default: ;
    endcase
  endtask

  task automatic load_ctrl(int s, bit wild);
    logic [31:0] v [3];
    int ax;
    for (ax = 0; ax < 3; ax++) begin
      case ($urandom_range(wild ? 3 : 1))
        0: v[ax] = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        1: v[ax] = $urandom;
        2: v[ax] = 32'h7FFF_FFFF;
        default: v[ax] = 32'h8000_0000;
      endcase
    end
    send_item(MODE_CTRL, s, v[0], v[1], v[2], $urandom, $urandom, 1'b0, '0);
  endtask

  // knot vector: 0 sorted with repeats, 1 clamped bezier, 2 noise
  task automatic load_knots(int style, int n);
    logic [31:0] v;
    int s, seg;
    v = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    for (s = 0; s < 68; s++) begin
      case (style)
        0: if (s > 0 && $urandom_range(3) != 0) v = v + $urandom_range(1, 32'h0002_0000);
        1: begin
          seg = s < 4 ? 0 : (s >= n ? (n - 1) / 3 : (s - 1) / 3);
          v = seg * 65536;
        end
        default: v = $urandom;
      endcase
      send_item(MODE_KNOT, s, $urandom, $urandom, $urandom, v, $urandom, 1'b0, '0);
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [6:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEGREE:   deg_m = val[1:0];
      CFG_CONTROLS: cnt_m = val;
      CFG_KNOTS:    kn_m  = val;
      default: ;
    endcase
  endtask

  // let every outstanding evaluation and queued load drain
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (point_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // output side: random stall, compare, watchdog
  always @(posedge clk) begin
    point_t w;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (point_q.size() == 0) begin
          $display("[%0t] unexpected result transaction", $time);
          errors++;
        end else begin
          w = point_q.pop_front();
          status_seen[rst_code]++;
          if (rx !== w.x) report_mismatch("result_x", rx, w.x);
          if (ry !== w.y) report_mismatch("result_y", ry, w.y);
          if (rz !== w.z) report_mismatch("result_z", rz, w.z);
          if (rst_code !== w.st) report_mismatch("eval_status", rst_code, w.st);
        end
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("watchdog expired with %0d results outstanding", point_q.size());
        $display("Verification failed");
        $finish;
      end
      out_stall <= !calm && ($urandom_range(99) < STALL_PCT);
    end
  end

  row_t dir_rows [14];
  int   cfgs [12][4];

  initial begin
    int r, ph, it, s, nseg, style, pick;
    logic [18:0] tv;
    // directed rows; empty store answers are known without prediction
    dir_rows[0]  = '{MODE_EVAL, 7'd0,   0, 0, 0, 0, 19'd0,      1'b1, '{0, 0, 0, ST_EMPTY}};
    dir_rows[1]  = '{MODE_EVAL, 7'd0,   0, 0, 0, 0, 19'h60000,  1'b1, '{0, 0, 0, ST_EMPTY}};
    dir_rows[2]  = '{MODE_EVAL, 7'd0,   0, 0, 0, 0, 19'h20000,  1'b1, '{0, 0, 0, ST_EMPTY}};
    dir_rows[3]  = '{MODE_CTRL, 7'd64,  1, 2, 3, 0, 19'd0,      1'b0, '0};
    dir_rows[4]  = '{MODE_CTRL, 7'd127, 1, 2, 3, 0, 19'd0,      1'b0, '0};
    dir_rows[5]  = '{MODE_KNOT, 7'd68,  0, 0, 0, 5, 19'd0,      1'b0, '0};
    dir_rows[6]  = '{MODE_KNOT, 7'd127, 0, 0, 0, 5, 19'd0,      1'b0, '0};
    dir_rows[7]  = '{MODE_NONE, 7'd5,   0, 0, 0, 0, 19'd0,      1'b0, '0};
    dir_rows[8]  = '{MODE_CTRL, 7'd0,   32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 0, 1'b0, '0};
    dir_rows[9]  = '{MODE_CTRL, 7'd63,  32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, 0, 1'b0, '0};
    dir_rows[10] = '{MODE_KNOT, 7'd0,   0, 0, 0, 32'h80000000, 19'd0, 1'b0, '0};
    dir_rows[11] = '{MODE_KNOT, 7'd67,  0, 0, 0, 32'h7FFFFFFF, 19'd0, 1'b0, '0};
    dir_rows[12] = '{MODE_EVAL, 7'd127, 0, 0, 0, 0, 19'h7FFFF,  1'b1, '{0, 0, 0, ST_EMPTY}};
    dir_rows[13] = '{MODE_EVAL, 7'd0,   0, 0, 0, 0, 19'h10000,  1'b1, '{0, 0, 0, ST_EMPTY}};
    // degree, controls, knots, knot style
    cfgs = '{'{3, 4, 8, 1}, '{3, 7, 11, 1}, '{3, 64, 68, 1}, '{3, 127, 127, 1},
             '{0, 5, 9, 0}, '{1, 2, 4, 0}, '{2, 64, 68, 0}, '{3, 10, 14, 2},
             '{2, 10, 3, 0}, '{3, 3, 7, 0}, '{1, 1, 0, 0}, '{3, 13, 17, 2}};
    deg_m = 3; cnt_m = 0; kn_m = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < 14; r++)
      send_item(dir_rows[r].mode, dir_rows[r].slot, dir_rows[r].x, dir_rows[r].y,
                dir_rows[r].z, dir_rows[r].k, dir_rows[r].t, dir_rows[r].typed,
                dir_rows[r].want);
    // fill both stores so no unwritten entry is ever read
    for (s = 1; s < 63; s++) load_ctrl(s, 1'b0);
    for (s = 1; s < 67; s++)
      send_item(MODE_KNOT, s, 0, 0, 0, s * 32'h1_0000, 0, 1'b0, '0);

    for (ph = 0; ph < 16; ph++) begin
      drain();
      calm = (ph == 4 || ph == 5);
      if (ph < 12) begin
        write_reg(CFG_DEGREE, cfgs[ph][0]);
        write_reg(CFG_CONTROLS, cfgs[ph][1]);
        write_reg(CFG_KNOTS, cfgs[ph][2]);
        style = cfgs[ph][3];
      end else begin
        write_reg(CFG_DEGREE, $urandom_range(3));
        nseg = $urandom_range(1, 21);
        pick = $urandom_range(2);
        write_reg(CFG_CONTROLS, pick == 0 ? 3 * nseg + 1 : $urandom_range(1, 64));
        write_reg(CFG_KNOTS, pick == 0 ? cnt_m + 4 : $urandom_range(127));
        style = $urandom_range(2);
      end
      load_knots(style, cnt_m > 64 ? 64 : cnt_m);
      for (s = 0; s < 64; s++) load_ctrl(s, ph % 3 == 0);
      // parameter extremes first, then random evaluations with some reloads
      send_item(MODE_EVAL, 0, 0, 0, 0, 0, 19'h40000, 1'b0, '0);
      send_item(MODE_EVAL, 0, 0, 0, 0, 0, 19'h20000, 1'b0, '0);
      send_item(MODE_EVAL, 0, 0, 0, 0, 0, 19'h10000, 1'b0, '0);
      send_item(MODE_EVAL, 0, 0, 0, 0, 0, 19'h0,     1'b0, '0);
      for (it = 0; it < 60; it++) begin
        pick = $urandom_range(99);
        if (pick < 8) load_ctrl($urandom_range(127), 1'b1);
        else if (pick < 11)
          send_item(MODE_KNOT, $urandom_range(127), 0, 0, 0, $urandom, 0, 1'b0, '0);
        else if (pick < 13)
          send_item(MODE_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, 1'b0, '0);
        else begin
          tv = pick < 85 ? 19'($urandom_range(65536)) : 19'($urandom);
          send_item(MODE_EVAL, $urandom, $urandom, $urandom, $urandom, $urandom,
                    tv, 1'b0, '0);
        end
      end
    end
    drain();

    $display("evaluations checked: de Boor %0d, Bezier %0d, linear %0d, empty %0d",
             status_seen[ST_DEBOOR], status_seen[ST_BEZIER], status_seen[ST_LINEAR],
             status_seen[ST_EMPTY]);
    $display("16 register settings walked, %0d mismatches", errors);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
